// File: design/ats_pkg.sv
package ats_pkg;

    localparam int OFFSET_W = 31;
    localparam int LENGTH_W = 16;
    localparam int KIND_W   = 5;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_PLUS        = 5'd0;
    localparam logic [KIND_W-1:0] KIND_MINUS       = 5'd1;
    localparam logic [KIND_W-1:0] KIND_SLASH       = 5'd2;
    localparam logic [KIND_W-1:0] KIND_STAR        = 5'd3;
    localparam logic [KIND_W-1:0] KIND_DOT         = 5'd4;
    localparam logic [KIND_W-1:0] KIND_COMMA       = 5'd5;
    localparam logic [KIND_W-1:0] KIND_COLON       = 5'd6;
    localparam logic [KIND_W-1:0] KIND_SEMICOLON   = 5'd7;
    localparam logic [KIND_W-1:0] KIND_QUOTE       = 5'd8;
    localparam logic [KIND_W-1:0] KIND_QUESTION    = 5'd9;
    localparam logic [KIND_W-1:0] KIND_END         = 5'd10;
    localparam logic [KIND_W-1:0] KIND_INVALID     = 5'd11;
    localparam logic [KIND_W-1:0] KIND_NAME        = 5'd12;
    localparam logic [KIND_W-1:0] KIND_REG         = 5'd13;
    localparam logic [KIND_W-1:0] KIND_INT         = 5'd14;
    localparam logic [KIND_W-1:0] KIND_FLOAT       = 5'd15;
    localparam logic [KIND_W-1:0] KIND_STRING      = 5'd16;
    localparam logic [KIND_W-1:0] KIND_ERR_NEWLINE = 5'd17;
    localparam logic [KIND_W-1:0] KIND_ERR_UNTERM  = 5'd18;
    localparam logic [KIND_W-1:0] KIND_ERR_DOTS    = 5'd19;

    // characters
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] start;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } tok_t;

    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            CH_PLUS:      k = KIND_PLUS;
            CH_MINUS:     k = KIND_MINUS;
            CH_SLASH:     k = KIND_SLASH;
            CH_STAR:      k = KIND_STAR;
            CH_DOT:       k = KIND_DOT;
            CH_COMMA:     k = KIND_COMMA;
            CH_COLON:     k = KIND_COLON;
            CH_SEMICOLON: k = KIND_SEMICOLON;
            CH_QUOTE:     k = KIND_QUOTE;
            CH_QUESTION:  k = KIND_QUESTION;
            default:      k = KIND_INVALID;
        endcase
        return k;
    endfunction

endpackage

// File: design/assembly_token_scanner_top.sv
// channel  | direction | tdata                            | tuser      | tlast
// s_axis   | in        | in_byte[7:0]                     | -          | in_end
// m_axis   | out       | token_start[30:0], token_length  | token_kind | last_of_run
//
// one byte word is taken per cycle while s_axis_tready is high; a word that
// closes one token and emits a second gives two result words, which leave one per
// cycle while m_axis_tready is high, through a three-entry output queue.
// s_axis_tready is high while at most one result waits, so a stream with one result
// per word runs at one word per cycle while m_axis_tready stays high. reset clears
// the scanner state and empties the queue; an error halts the scanner until reset.
module assembly_token_scanner_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // token_start[30:0], token_length[46:31], zero
    output logic [ats_pkg::KIND_W-1:0] m_axis_tuser,  // token_kind[4:0]
    output logic        m_axis_tlast
);
    import ats_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NAME, ST_REG, ST_NUM, ST_STR, ST_DONE, ST_HALT
    } mode_t;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = {LENGTH_W{1'b1}};

    mode_t               mode_reg, mode_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [OFFSET_W-1:0] origin_reg, origin_next;
    logic [LENGTH_W-1:0] count_reg, count_next;
    logic                seen_dot_reg, seen_dot_next;
    logic                prior_dot_reg, prior_dot_next;

    tok_t                q_reg [0:2];
    tok_t                q_next [0:2];
    logic [1:0]          fill_reg, fill_next;

    tok_t                res [0:1];
    logic [1:0]          n_res;

    logic [7:0]          b;
    logic                is_letter, is_digit, is_name_char, is_ws;
    logic [OFFSET_W-1:0] p_inc;
    logic [LENGTH_W-1:0] count_inc;
    logic [KIND_W-1:0]   close_kind;
    logic                closing, rescan;
    logic                push, pop;
    logic [1:0]          base;

    assign b            = s_axis_tdata;
    assign is_letter    = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    assign is_digit     = (b >= 8'h30 && b <= 8'h39);
    assign is_name_char = is_letter || is_digit || (b == CH_UNDER);
    assign is_ws        = (b == CH_NEWLINE) || (b == CH_TAB) || (b == CH_SPACE);
    assign p_inc        = (offset_reg == OFFSET_MAX) ? offset_reg : offset_reg + 1'b1;
    assign count_inc    = (count_reg == LENGTH_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        case (mode_reg)
            ST_REG:  close_kind = KIND_REG;
            ST_NUM:  close_kind = seen_dot_reg ? KIND_FLOAT : KIND_INT;
            default: close_kind = KIND_NAME;
        endcase
    end

    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = m_axis_tvalid && m_axis_tready;

    // scanner: results of the current word
    always_comb
    begin
        mode_next      = mode_reg;
        offset_next    = offset_reg;
        origin_next    = origin_reg;
        count_next     = count_reg;
        seen_dot_next  = seen_dot_reg;
        prior_dot_next = prior_dot_reg;
        res[0]         = '0;
        res[1]         = '0;
        n_res          = 2'd0;
        closing        = 1'b0;
        rescan         = 1'b0;

        if (mode_reg == ST_HALT)
        begin
            n_res = 2'd0;
        end
        else if (mode_reg == ST_DONE)
        begin
            if (s_axis_tlast)
            begin
                res[0] = '{KIND_END, offset_reg, '0, 1'b0};
                n_res  = 2'd1;
            end
        end
        else if (s_axis_tlast)
        begin
            if (mode_reg == ST_STR)
            begin
                res[0]    = '{KIND_ERR_UNTERM, offset_reg, '0, 1'b0};
                n_res     = 2'd1;
                mode_next = ST_HALT;
            end
            else
            begin
                if (mode_reg != ST_IDLE)
                begin
                    res[0] = '{close_kind, origin_reg, count_reg, 1'b0};
                    n_res  = 2'd1;
                end
                res[n_res[0]] = '{KIND_END, offset_reg, '0, 1'b0};
                n_res         = n_res + 2'd1;
                mode_next     = ST_DONE;
            end
        end
        else
        begin
            case (mode_reg)
                ST_NAME, ST_REG:
                begin
                    if (is_name_char)
                        count_next = count_inc;
                    else
                        closing = 1'b1;
                end
                ST_NUM:
                begin
                    if (is_digit)
                    begin
                        count_next     = count_inc;
                        prior_dot_next = 1'b0;
                    end
                    else if (b == CH_DOT)
                    begin
                        if (prior_dot_reg)
                        begin
                            res[0]    = '{KIND_ERR_DOTS, p_inc, '0, 1'b0};
                            n_res     = 2'd1;
                            mode_next = ST_HALT;
                        end
                        else
                        begin
                            count_next     = count_inc;
                            seen_dot_next  = 1'b1;
                            prior_dot_next = 1'b1;
                        end
                    end
                    else
                    begin
                        closing = 1'b1;
                    end
                end
                ST_STR:
                begin
                    if (b == CH_DQUOTE)
                    begin
                        res[0]    = '{KIND_STRING, origin_reg, count_reg, 1'b0};
                        n_res     = 2'd1;
                        mode_next = ST_IDLE;
                    end
                    else if (b == CH_NEWLINE)
                    begin
                        res[0]    = '{KIND_ERR_NEWLINE, p_inc, '0, 1'b0};
                        n_res     = 2'd1;
                        mode_next = ST_HALT;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase

            if (closing)
            begin
                res[0]    = '{close_kind, origin_reg, count_reg, 1'b0};
                n_res     = 2'd1;
                mode_next = ST_IDLE;
                rescan    = 1'b1;
            end

            // the byte that ended a token is scanned again from idle
            if (rescan)
            begin
                if (is_ws)
                begin
                    mode_next = ST_IDLE;
                end
                else if (is_letter || is_digit || b == CH_PERCENT)
                begin
                    mode_next      = is_letter ? ST_NAME :
                                     (b == CH_PERCENT ? ST_REG : ST_NUM);
                    origin_next    = offset_reg;
                    count_next     = {{(LENGTH_W-1){1'b0}}, 1'b1};
                    seen_dot_next  = 1'b0;
                    prior_dot_next = 1'b0;
                end
                else if (b == CH_DQUOTE)
                begin
                    mode_next   = ST_STR;
                    origin_next = p_inc;
                    count_next  = '0;
                end
                else
                begin
                    mode_next     = ST_IDLE;
                    res[n_res[0]] = '{punct_kind(b), offset_reg, '0, 1'b0};
                    n_res         = n_res + 2'd1;
                end
            end

            offset_next = p_inc;
        end

        if (n_res == 2'd2)
            res[1].last = 1'b1;
        else if (n_res == 2'd1)
            res[0].last = 1'b1;
    end

    // output queue
    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        q_next[2] = q_reg[2];
        fill_next = fill_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            fill_next = fill_reg - 2'd1;
        end
        base = fill_next;
        if (push)
        begin
            if (n_res != 2'd0)
                q_next[base] = res[0];
            if (n_res == 2'd2)
                q_next[base + 2'd1] = res[1];
            fill_next = fill_next + n_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_IDLE;
            offset_reg    <= '0;
            origin_reg    <= '0;
            count_reg     <= '0;
            seen_dot_reg  <= 1'b0;
            prior_dot_reg <= 1'b0;
            fill_reg      <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                mode_reg      <= mode_next;
                offset_reg    <= offset_next;
                origin_reg    <= origin_next;
                count_reg     <= count_next;
                seen_dot_reg  <= seen_dot_next;
                prior_dot_reg <= prior_dot_next;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

    assign s_axis_tready = !fill_reg[1];
    assign m_axis_tvalid = (fill_reg != 2'd0);
    assign m_axis_tdata  = {1'b0, q_reg[0].length, q_reg[0].start};
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tlast  = q_reg[0].last;

endmodule

// File: design/assembly_token_scanner_checker.sv
module assembly_token_scanner_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [ats_pkg::KIND_W-1:0] m_axis_tuser,
    input logic        m_axis_tlast
);
    import ats_pkg::*;

    // queue is empty right after reset
    a_empty_after_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result word present after reset");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= KIND_ERR_DOTS))
        else $error("token kind out of range");

    // punctuation, end, invalid and error tokens carry no length
    a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser <= KIND_QUESTION || m_axis_tuser == KIND_END
            || m_axis_tuser == KIND_INVALID || m_axis_tuser >= KIND_ERR_NEWLINE)
        |-> (m_axis_tdata[46:31] == 16'd0))
        else $error("nonzero length on a fixed-length token");

    // an error is always the final word of its input word
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser >= KIND_ERR_NEWLINE |-> m_axis_tlast)
        else $error("error token not marked last");

    // a waiting result word holds still until taken
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

endmodule

bind assembly_token_scanner_top assembly_token_scanner_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: test/assembly_token_scanner_top_tb.sv
module assembly_token_scanner_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ats_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 48;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_WORDS    = 330;

    typedef enum logic [2:0] {
        SM_IDLE,
        SM_NAME,
        SM_REG,
        SM_NUM,
        SM_STR,
        SM_DONE,
        SM_HALT
    } scan_mode_e;

    typedef enum int {
        STOP_END,
        STOP_NEWLINE,
        STOP_UNTERM,
        STOP_DOTS
    } stop_e;

    typedef struct {
        logic [7:0]          b;
        logic                e;
        logic                typed;
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] start;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [KIND_W-1:0] m_axis_tuser;
    logic        m_axis_tlast;

    // scanner shadow state
    scan_mode_e          sm;
    logic [OFFSET_W-1:0] at_offset;
    logic [OFFSET_W-1:0] tok_origin;
    logic [LENGTH_W-1:0] tok_len;
    logic                num_dot;
    logic                prev_dot;
    tok_t                step_toks[$];
    tok_t                tokens_due[$];

    int   send_idle_pct;
    int   recv_idle_pct;
    logic guard_errors;
    logic hold_start;
    int   hold_left;
    bit   hold_done;
    int   quiet_cycles;
    int   mismatches;
    int   tokens_seen;
    int   words_sent;
    stop_e stop;

    assembly_token_scanner_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [OFFSET_W-1:0] offset_inc(input logic [OFFSET_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LENGTH_W-1:0] length_inc(input logic [LENGTH_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic [KIND_W-1:0] punct_to_kind(input logic [7:0] c);
        case (c)
            CH_PLUS:      return KIND_PLUS;
            CH_MINUS:     return KIND_MINUS;
            CH_SLASH:     return KIND_SLASH;
            CH_STAR:      return KIND_STAR;
            CH_DOT:       return KIND_DOT;
            CH_COMMA:     return KIND_COMMA;
            CH_COLON:     return KIND_COLON;
            CH_SEMICOLON: return KIND_SEMICOLON;
            CH_QUOTE:     return KIND_QUOTE;
            CH_QUESTION:  return KIND_QUESTION;
            default:      return KIND_INVALID;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(0, 9))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_SLASH;
            3:       return CH_STAR;
            4:       return CH_DOT;
            5:       return CH_COMMA;
            6:       return CH_COLON;
            7:       return CH_SEMICOLON;
            8:       return CH_QUOTE;
            default: return CH_QUESTION;
        endcase
    endfunction

    function automatic logic [7:0] rand_name_char();
        case ($urandom_range(0, 3))
            0:       return 8'("A" + $urandom_range(0, 25));
            1:       return 8'("a" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    task automatic add_tok(input logic [KIND_W-1:0] kind, input logic [OFFSET_W-1:0] start,
                           input logic [LENGTH_W-1:0] len);
        tok_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.last   = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic close_token();
        logic [KIND_W-1:0] kind;
        kind = KIND_NAME;
        if (sm == SM_REG)
            kind = KIND_REG;
        else if (sm == SM_NUM)
            kind = num_dot ? KIND_FLOAT : KIND_INT;
        sm = SM_IDLE;
        add_tok(kind, tok_origin, tok_len);
    endtask

    // a byte seen with no token open
    task automatic begin_token(input logic [7:0] c, input logic [OFFSET_W-1:0] p);
        if (c == CH_NEWLINE || c == CH_TAB || c == CH_SPACE)
            return;
        if (is_letter(c) || is_digit(c) || c == CH_PERCENT)
        begin
            sm = is_letter(c) ? SM_NAME : (c == CH_PERCENT ? SM_REG : SM_NUM);
            tok_origin = p;
            tok_len    = LENGTH_W'(1);
            num_dot    = 1'b0;
            prev_dot   = 1'b0;
        end
        else if (c == CH_DQUOTE)
        begin
            sm = SM_STR;
            tok_origin = offset_inc(p);
            tok_len    = '0;
        end
        else
        begin
            add_tok(punct_to_kind(c), p, '0);
        end
    endtask

    task automatic scan_word(input logic [7:0] c, input logic e);
        logic [OFFSET_W-1:0] p;
        p = at_offset;
        step_toks.delete();
        if (sm == SM_HALT)
            return;
        if (sm == SM_DONE)
        begin
            if (e)
                add_tok(KIND_END, at_offset, '0);
        end
        else if (e)
        begin
            if (sm == SM_STR)
            begin
                add_tok(KIND_ERR_UNTERM, at_offset, '0);
                sm = SM_HALT;
            end
            else
            begin
                if (sm != SM_IDLE)
                    close_token();
                add_tok(KIND_END, at_offset, '0);
                sm = SM_DONE;
            end
        end
        else
        begin
            case (sm)
                SM_NAME, SM_REG:
                begin
                    if (is_name_char(c))
                        tok_len = length_inc(tok_len);
                    else
                    begin
                        close_token();
                        begin_token(c, p);
                    end
                end
                SM_NUM:
                begin
                    if (is_digit(c))
                    begin
                        tok_len  = length_inc(tok_len);
                        prev_dot = 1'b0;
                    end
                    else if (c == CH_DOT)
                    begin
                        if (prev_dot)
                        begin
                            add_tok(KIND_ERR_DOTS, offset_inc(p), '0);
                            sm = SM_HALT;
                        end
                        else
                        begin
                            tok_len  = length_inc(tok_len);
                            num_dot  = 1'b1;
                            prev_dot = 1'b1;
                        end
                    end
                    else
                    begin
                        close_token();
                        begin_token(c, p);
                    end
                end
                SM_STR:
                begin
                    if (c == CH_DQUOTE)
                    begin
                        add_tok(KIND_STRING, tok_origin, tok_len);
                        sm = SM_IDLE;
                    end
                    else if (c == CH_NEWLINE)
                    begin
                        add_tok(KIND_ERR_NEWLINE, offset_inc(p), '0);
                        sm = SM_HALT;
                    end
                    else
                        tok_len = length_inc(tok_len);
                end
                default:
                begin
                    sm = SM_IDLE;
                    begin_token(c, p);
                end
            endcase
            at_offset = offset_inc(p);
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].last = 1'b1;
    endtask

    task automatic send_word(input logic [7:0] b_in, input logic e, input logic typed,
                             input tok_t typed_tok);
        logic [7:0] c;
        c = b_in;
        // keep the random stream clear of the halting errors
        if (guard_errors)
        begin
            if (sm == SM_STR && c == CH_NEWLINE)
                c = CH_SPACE;
            if (sm == SM_NUM && prev_dot && c == CH_DOT)
                c = "0";
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= e;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        scan_word(c, e);
        if (typed)
            tokens_due.push_back(typed_tok);
        else
            foreach (step_toks[i])
                tokens_due.push_back(step_toks[i]);
    endtask

    task automatic put(input logic [7:0] c);
        send_word(c, 1'b0, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_due.size() != 0);
    endtask

    task automatic gen_token();
        int         pick;
        int         n;
        logic       dot_last;
        logic       want_float;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            put(8'("a" + $urandom_range(0, 25) - ($urandom_range(0, 1) ? 8'd32 : 8'd0)));
            n = $urandom_range(0, 7);
            repeat (n) put(rand_name_char());
        end
        else if (pick < 28)
        begin
            put(CH_PERCENT);
            n = $urandom_range(0, 5);
            repeat (n) put(rand_name_char());
        end
        else if (pick < 50)
        begin
            want_float = (pick >= 40);
            dot_last   = 1'b0;
            put(8'("0" + $urandom_range(0, 9)));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
            begin
                if (want_float && !dot_last && (i == 0 || $urandom_range(0, 2) == 0))
                begin
                    put(CH_DOT);
                    dot_last = 1'b1;
                end
                else
                begin
                    put(8'("0" + $urandom_range(0, 9)));
                    dot_last = 1'b0;
                end
            end
        end
        else if (pick < 62)
        begin
            put(CH_DQUOTE);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                c = rand_byte();
                if (c == CH_DQUOTE || c == CH_NEWLINE)
                    c = "s";
                put(c);
            end
            // now and then leave the string open for later bytes to join
            if ($urandom_range(0, 9) != 0)
                put(CH_DQUOTE);
        end
        else if (pick < 80)
            put(rand_punct());
        else if (pick < 92)
        begin
            case ($urandom_range(0, 2))
                0:       put(CH_SPACE);
                1:       put(CH_TAB);
                default: put(CH_NEWLINE);
            endcase
        end
        else
            put(rand_byte());
        if ($urandom_range(0, 9) < 4)
            put($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int words);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = words_sent + words;
        while (words_sent < target)
            gen_token();
    endtask

    // receiver: random stalls plus one long hold-off
    initial
    begin
        m_axis_tready <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : token_check
        tok_t        want;
        logic [47:0] want_data;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tokens_seen++;
            if (tokens_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected token kind %0d data %h last %0b", $realtime,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = tokens_due.pop_front();
                want_data = {1'b0, want.length, want.start};
                if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data
                        || m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: want kind %0d start %0d len %0d last %0b, ",
                                  "got kind %0d start %0d len %0d pad %0b last %0b"},
                                 $realtime, want.kind, want.start, want.length, want.last,
                                 m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[46:31],
                                 m_axis_tdata[47], m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t   dir_rows[31];
        tok_t       typed_tok;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        hold_start    <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        guard_errors  = 1'b1;
        words_sent    = 0;
        sm         = SM_IDLE;
        at_offset  = '0;
        tok_origin = '0;
        tok_len    = '0;
        num_dot    = 1'b0;
        prev_dot   = 1'b0;

        dir_rows = '{
            '{CH_PLUS,      1'b0, 1'b1, KIND_PLUS,      31'd0},
            '{CH_MINUS,     1'b0, 1'b1, KIND_MINUS,     31'd1},
            '{CH_SLASH,     1'b0, 1'b1, KIND_SLASH,     31'd2},
            '{CH_STAR,      1'b0, 1'b1, KIND_STAR,      31'd3},
            '{CH_DOT,       1'b0, 1'b1, KIND_DOT,       31'd4},
            '{CH_COMMA,     1'b0, 1'b1, KIND_COMMA,     31'd5},
            '{CH_COLON,     1'b0, 1'b1, KIND_COLON,     31'd6},
            '{CH_SEMICOLON, 1'b0, 1'b1, KIND_SEMICOLON, 31'd7},
            '{CH_QUOTE,     1'b0, 1'b1, KIND_QUOTE,     31'd8},
            '{CH_QUESTION,  1'b0, 1'b1, KIND_QUESTION,  31'd9},
            '{8'h00,        1'b0, 1'b1, KIND_INVALID,   31'd10},
            '{8'hFF,        1'b0, 1'b1, KIND_INVALID,   31'd11},
            '{CH_TAB,       1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{"a",          1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{"Z",          1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_UNDER,     1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{"9",          1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_COMMA,     1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_PERCENT,   1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{"r",          1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_SPACE,     1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{"0",          1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_DOT,       1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{"5",          1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_NEWLINE,   1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{"7",          1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_DQUOTE,    1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{8'h80,        1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_DQUOTE,    1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_DQUOTE,    1'b0, 1'b0, KIND_INVALID,   31'd0},
            '{CH_DQUOTE,    1'b0, 1'b0, KIND_INVALID,   31'd0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 71;
        foreach (dir_rows[i])
        begin
            typed_tok.kind   = dir_rows[i].kind;
            typed_tok.start  = dir_rows[i].start;
            typed_tok.length = '0;
            typed_tok.last   = 1'b1;
            send_word(dir_rows[i].b, dir_rows[i].e, dir_rows[i].typed, typed_tok);
        end

        run_phase(12, 71, PHASE_WORDS);
        wait_drained();
        run_phase(71, 12, PHASE_WORDS);
        wait_drained();

        // long receiver hold while punctuation words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start <= 1'b1;
        repeat (40) put(rand_punct());
        run_phase(0, 0, PHASE_WORDS);

        while (sm != SM_IDLE)
            put(sm == SM_STR ? CH_DQUOTE : CH_SPACE);
        guard_errors = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 12;
        stop = stop_e'($urandom_range(0, 3));
        case (stop)
            STOP_END:
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        put("a");
                        put("b");
                    end
                    1:
                    begin
                        put(CH_PERCENT);
                        put("x");
                    end
                    2:
                    begin
                        put("3");
                        put(CH_DOT);
                        put("1");
                    end
                    default: ;
                endcase
                send_word(rand_byte(), 1'b1, 1'b0, '0);
                repeat (3) put(rand_byte());
                send_word(rand_byte(), 1'b1, 1'b0, '0);
            end
            STOP_NEWLINE:
            begin
                put(CH_DQUOTE);
                if ($urandom_range(0, 1))
                    put("q");
                put(CH_NEWLINE);
            end
            STOP_UNTERM:
            begin
                put(CH_DQUOTE);
                put("q");
                send_word(rand_byte(), 1'b1, 1'b0, '0);
            end
            default:
            begin
                put("4");
                put(CH_DOT);
                put(CH_DOT);
            end
        endcase
        // once stopped, bytes give nothing; after an end only end words answer, after an error nothing does
        repeat (4) send_word(rand_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("scanned %0d byte words into %0d tokens under mixed stalls and a long hold",
                 words_sent, tokens_seen);
        $display("stream closed by %s, %0d mismatches", stop.name(), mismatches);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
